// File: hw/rtl/brfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brfc_pkg
// Shared types, codes and the crc-8 step for the reply frame checker.
// ----------------------------------------------------------------------------
package brfc_pkg;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 16;
    localparam int COUNT_W = 32;
    localparam int CHAN_W  = 4;
    localparam int ADDR_W  = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0]  CRC_POLY         = 8'h07;
    localparam logic [VALUE_W-1:0] MIN_MODULE_RESET = 16'hFFFF;
    localparam logic [VALUE_W-1:0] MIN_CELL_RESET   = 16'd13107;
    localparam logic [VALUE_W-1:0] MAX_RESET        = 16'd0;
    localparam logic [BYTE_W-1:0]  DATA_REG_RESET   = 8'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODULE_ADDRESS = 2'd0,
        REG_DATA_REGISTER  = 2'd1
    } t_reg_index;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_SHORT  = 2'd1,
        STATUS_CRC    = 2'd2,
        STATUS_HEADER = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERROR,
        ST_RD_HI,
        ST_RD_LO,
        ST_CALC,
        ST_EMIT
    } t_state;

    // msb-first crc-8, no reflection, no final xor
    function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int i = 0; i < BYTE_W; i++) begin
            c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/brfc_rx_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brfc_rx_if
// Reply byte channel: one received byte and its end-of-frame flag.
// ----------------------------------------------------------------------------
interface brfc_rx_if;
    logic                         valid;
    logic                         ready;
    logic [brfc_pkg::BYTE_W-1:0]  rx_byte;
    logic                         end_of_frame;

    modport source (output valid, output rx_byte, output end_of_frame, input ready);
    modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/brfc_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brfc_res_if
// Result channel: per-channel code, running extremes and frame counters.
// ----------------------------------------------------------------------------
interface brfc_res_if;
    logic                          valid;
    logic                          ready;
    brfc_pkg::t_status             status;
    logic [brfc_pkg::CHAN_W-1:0]   channel;
    logic [brfc_pkg::VALUE_W-1:0]  raw_value;
    logic [brfc_pkg::VALUE_W-1:0]  run_min;
    logic [brfc_pkg::VALUE_W-1:0]  run_max;
    logic [brfc_pkg::COUNT_W-1:0]  good_count;
    logic [brfc_pkg::COUNT_W-1:0]  bad_count;
    logic                          last_result;

    modport source (output valid, output status, output channel, output raw_value,
                    output run_min, output run_max, output good_count, output bad_count,
                    output last_result, input ready);
    modport sink   (input valid, input status, input channel, input raw_value,
                    input run_min, input run_max, input good_count, input bad_count,
                    input last_result, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/brfc_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brfc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface brfc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [brfc_pkg::CFG_IDX_W-1:0] reg_index;
    logic [brfc_pkg::BYTE_W-1:0]    wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bms_reply_frame_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bms_reply_frame_checker
// Checks battery monitor read replies and emits per-channel codes.
// ----------------------------------------------------------------------------
// Reply bytes are taken one per clock while no frame end is being handled.
// Bytes 0..2 are checked against the address, register and length header,
// data bytes go to a small byte memory, and a crc-8 (poly 0x07) runs over
// all bytes but the last of the frame. On the end-of-frame byte the input
// stops: a short, crc-failed or header-failed frame gives one error result
// once the output register is free; a good frame reads the stored bytes
// back and gives CELL_COUNT+3 results, each from two reads of the single
// byte-memory port, a read-modify-write of the min/max memory and the load
// of the output register, which waits out result-side stalls. The output
// register lets the next frame's bytes flow while the last result waits.
// ----------------------------------------------------------------------------
module bms_reply_frame_checker #(
    parameter int FRAME_BYTES = 22,
    parameter int CELL_COUNT  = 6
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    brfc_rx_if.sink        i_rx,
    brfc_cfg_if.sink       i_cfg,
    brfc_res_if.source     o_res
);

    localparam int CHANNELS   = CELL_COUNT + 3;
    localparam int DATA_BYTES = 2 * CHANNELS;
    localparam int CNT_W      = $clog2(FRAME_BYTES + 1);
    localparam int DADDR_W    = $clog2(DATA_BYTES);
    localparam int CH_W       = $clog2(CHANNELS);
    localparam int MM_DEPTH   = CELL_COUNT + 1;
    localparam int MM_W       = $clog2(MM_DEPTH);
    localparam int BW         = brfc_pkg::BYTE_W;
    localparam int VW         = brfc_pkg::VALUE_W;
    localparam int KW         = brfc_pkg::COUNT_W;
    localparam logic [BW-1:0] LEN_BYTE = BW'(DATA_BYTES);

    // configuration
    logic [brfc_pkg::ADDR_W-1:0] r_module_address;
    logic [BW-1:0]               r_data_register;

    // frame accumulation
    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic [BW-1:0]    r_crc, n_crc;
    logic [BW-1:0]    r_rx_crc, n_rx_crc;
    logic             r_hdr_ok, n_hdr_ok;
    logic [KW-1:0]    r_good, r_bad;
    brfc_pkg::t_status r_err_status, n_err_status;

    // sequencer
    brfc_pkg::t_state r_state, n_state;
    logic [CH_W-1:0]  r_ch;
    logic             ch_last;
    logic             slot_free;
    logic             out_load_err, out_load_ok;

    // memories
    logic [BW-1:0]      r_dmem [DATA_BYTES];
    logic [BW-1:0]      r_dmem_q;
    logic [DADDR_W-1:0] dmem_raddr;
    logic               dmem_we;
    logic [DADDR_W-1:0] dmem_waddr;

    logic [2*VW-1:0]    r_mm [MM_DEPTH];
    logic [2*VW-1:0]    r_mm_q;
    logic               r_mm_hit;
    logic [MM_DEPTH-1:0] r_mm_valid;
    logic [MM_W-1:0]    mm_addr;
    logic               mm_re, mm_we;
    logic               ch_tracked;

    // result staging
    logic [BW-1:0] r_hi;
    logic [VW-1:0] r_res_value, r_res_min, r_res_max;
    logic [VW-1:0] calc_value, old_min, old_max, new_min, new_max;

    // output register
    logic              r_out_valid;
    brfc_pkg::t_status r_out_status;
    logic [brfc_pkg::CHAN_W-1:0] r_out_channel;
    logic [VW-1:0]     r_out_value, r_out_min, r_out_max;
    logic [KW-1:0]     r_out_good, r_out_bad;
    logic              r_out_last;

    logic rx_xfer, cfg_xfer;
    logic frame_short, crc_bad;

    assign rx_xfer    = i_rx.valid && i_rx.ready;
    assign cfg_xfer   = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;
    assign i_rx.ready = (r_state == brfc_pkg::ST_IDLE);
    assign slot_free  = !r_out_valid || o_res.ready;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_module_address <= '0;
            r_data_register  <= brfc_pkg::DATA_REG_RESET;
        end else if (cfg_xfer) begin
            case (i_cfg.reg_index)
                brfc_pkg::REG_MODULE_ADDRESS: begin
                    r_module_address <= i_cfg.wr_data[brfc_pkg::ADDR_W-1:0];
                end
                brfc_pkg::REG_DATA_REGISTER: begin
                    r_data_register <= i_cfg.wr_data;
                end
                default: ;
            endcase
        end
    end

    // ---------------- byte intake ----------------
    always_comb begin
        n_byte_count = r_byte_count;
        n_crc        = r_crc;
        n_rx_crc     = r_rx_crc;
        n_hdr_ok     = r_hdr_ok;
        dmem_we      = 1'b0;
        dmem_waddr   = DADDR_W'(32'(r_byte_count) - 32'd3);
        if (r_byte_count < CNT_W'(FRAME_BYTES)) begin
            if (r_byte_count < CNT_W'(FRAME_BYTES - 1)) begin
                n_crc = brfc_pkg::crc8_update(r_crc, i_rx.rx_byte);
            end else begin
                n_rx_crc = i_rx.rx_byte;
            end
            if (r_byte_count == CNT_W'(0)
                && i_rx.rx_byte != {1'b0, r_module_address, 1'b0}) begin
                n_hdr_ok = 1'b0;
            end
            if (r_byte_count == CNT_W'(1) && i_rx.rx_byte != r_data_register) begin
                n_hdr_ok = 1'b0;
            end
            if (r_byte_count == CNT_W'(2) && i_rx.rx_byte != LEN_BYTE) begin
                n_hdr_ok = 1'b0;
            end
            if (32'(r_byte_count) >= 32'd3 && 32'(r_byte_count) - 32'd3 < 32'(DATA_BYTES)
                && r_byte_count < CNT_W'(FRAME_BYTES - 1)) begin
                dmem_we = rx_xfer;
            end
            n_byte_count = r_byte_count + CNT_W'(1);
        end
    end

    assign frame_short = n_byte_count < CNT_W'(FRAME_BYTES);
    assign crc_bad     = n_rx_crc != n_crc;

    always_comb begin
        if (frame_short) begin
            n_err_status = brfc_pkg::STATUS_SHORT;
        end else if (crc_bad) begin
            n_err_status = brfc_pkg::STATUS_CRC;
        end else if (!n_hdr_ok) begin
            n_err_status = brfc_pkg::STATUS_HEADER;
        end else begin
            n_err_status = brfc_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_crc        <= '0;
            r_rx_crc     <= '0;
            r_hdr_ok     <= 1'b1;
            r_good       <= '0;
            r_bad        <= '0;
            r_err_status <= brfc_pkg::STATUS_OK;
        end else if (rx_xfer) begin
            r_rx_crc <= n_rx_crc;
            if (i_rx.end_of_frame) begin
                r_byte_count <= '0;
                r_crc        <= '0;
                r_hdr_ok     <= 1'b1;
                r_err_status <= n_err_status;
                // counters move before any result of this frame is shown
                if (n_err_status == brfc_pkg::STATUS_OK) begin
                    r_good <= r_good + KW'(1);
                end else if (n_err_status != brfc_pkg::STATUS_HEADER) begin
                    r_bad <= r_bad + KW'(1);
                end
            end else begin
                r_byte_count <= n_byte_count;
                r_crc        <= n_crc;
                r_hdr_ok     <= n_hdr_ok;
            end
        end
    end

    // ---------------- sequencer ----------------
    assign ch_last    = (r_ch == CH_W'(CHANNELS - 1));
    assign ch_tracked = (32'(r_ch) < 32'(MM_DEPTH));
    assign mm_addr    = MM_W'(r_ch);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brfc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        out_load_err = 1'b0;
        out_load_ok  = 1'b0;
        mm_re        = 1'b0;
        mm_we        = 1'b0;
        dmem_raddr   = DADDR_W'({r_ch, 1'b0});
        case (r_state)
            brfc_pkg::ST_IDLE: begin
                if (rx_xfer && i_rx.end_of_frame) begin
                    n_state = (n_err_status == brfc_pkg::STATUS_OK) ?
                              brfc_pkg::ST_RD_HI : brfc_pkg::ST_ERROR;
                end
            end
            brfc_pkg::ST_ERROR: begin
                if (slot_free) begin
                    out_load_err = 1'b1;
                    n_state      = brfc_pkg::ST_IDLE;
                end
            end
            brfc_pkg::ST_RD_HI: begin
                n_state = brfc_pkg::ST_RD_LO;
            end
            brfc_pkg::ST_RD_LO: begin
                dmem_raddr = DADDR_W'({r_ch, 1'b1});
                mm_re      = ch_tracked;
                n_state    = brfc_pkg::ST_CALC;
            end
            brfc_pkg::ST_CALC: begin
                // each entry is touched once per frame, so no forwarding is needed
                mm_we   = ch_tracked;
                n_state = brfc_pkg::ST_EMIT;
            end
            brfc_pkg::ST_EMIT: begin
                if (slot_free) begin
                    out_load_ok = 1'b1;
                    n_state     = ch_last ? brfc_pkg::ST_IDLE : brfc_pkg::ST_RD_HI;
                end
            end
            default: n_state = brfc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch <= '0;
        end else if (out_load_ok) begin
            r_ch <= ch_last ? '0 : r_ch + CH_W'(1);
        end
    end

    // ---------------- data byte memory ----------------
    always_ff @(posedge i_clk) begin
        if (dmem_we) begin
            r_dmem[dmem_waddr] <= i_rx.rx_byte;
        end
        r_dmem_q <= r_dmem[dmem_raddr];
    end

    // ---------------- min/max memory ----------------
    always_ff @(posedge i_clk) begin
        if (mm_re) begin
            r_mm_q   <= r_mm[mm_addr];
            r_mm_hit <= r_mm_valid[mm_addr];
        end
        if (mm_we) begin
            r_mm[mm_addr] <= {new_min, new_max};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mm_valid <= '0;
        end else if (mm_we) begin
            r_mm_valid[mm_addr] <= 1'b1;
        end
    end

    // ---------------- compare and stage ----------------
    assign calc_value = {r_hi, r_dmem_q};
    always_comb begin
        if (r_mm_hit) begin
            old_min = r_mm_q[2*VW-1:VW];
            old_max = r_mm_q[VW-1:0];
        end else begin
            old_min = (r_ch == '0) ? brfc_pkg::MIN_MODULE_RESET : brfc_pkg::MIN_CELL_RESET;
            old_max = brfc_pkg::MAX_RESET;
        end
        new_min = (calc_value < old_min) ? calc_value : old_min;
        new_max = (calc_value > old_max) ? calc_value : old_max;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == brfc_pkg::ST_RD_LO) begin
            r_hi <= r_dmem_q;
        end
        if (r_state == brfc_pkg::ST_CALC) begin
            r_res_value <= calc_value;
            r_res_min   <= ch_tracked ? new_min : calc_value;
            r_res_max   <= ch_tracked ? new_max : calc_value;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load_err || out_load_ok) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load_err) begin
            r_out_status  <= r_err_status;
            r_out_channel <= '0;
            r_out_value   <= '0;
            r_out_min     <= '0;
            r_out_max     <= '0;
            r_out_good    <= r_good;
            r_out_bad     <= r_bad;
            r_out_last    <= 1'b1;
        end else if (out_load_ok) begin
            r_out_status  <= brfc_pkg::STATUS_OK;
            r_out_channel <= brfc_pkg::CHAN_W'(r_ch);
            r_out_value   <= r_res_value;
            r_out_min     <= r_res_min;
            r_out_max     <= r_res_max;
            r_out_good    <= r_good;
            r_out_bad     <= r_bad;
            r_out_last    <= ch_last;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.channel     = r_out_channel;
    assign o_res.raw_value   = r_out_value;
    assign o_res.run_min     = r_out_min;
    assign o_res.run_max     = r_out_max;
    assign o_res.good_count  = r_out_good;
    assign o_res.bad_count   = r_out_bad;
    assign o_res.last_result = r_out_last;

endmodule
`default_nettype wire

// File: hw/rtl/brfc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brfc_checker
// Port-level checks on the result channel of the reply frame checker.
// ----------------------------------------------------------------------------
module brfc_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_valid,
    input wire                          i_ready,
    input wire [1:0]                    i_status,
    input wire [brfc_pkg::CHAN_W-1:0]   i_channel,
    input wire [brfc_pkg::VALUE_W-1:0]  i_raw_value,
    input wire [brfc_pkg::VALUE_W-1:0]  i_run_min,
    input wire [brfc_pkg::VALUE_W-1:0]  i_run_max,
    input wire [brfc_pkg::COUNT_W-1:0]  i_good_count,
    input wire [brfc_pkg::COUNT_W-1:0]  i_bad_count,
    input wire                          i_last_result
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_status) && $stable(i_channel)
        && $stable(i_raw_value) && $stable(i_run_min) && $stable(i_run_max)
        && $stable(i_good_count) && $stable(i_bad_count) && $stable(i_last_result))
        else $error("result changed while stalled");

    // error results are a single zeroed item
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status != brfc_pkg::STATUS_OK |-> i_last_result && i_channel == '0
        && i_raw_value == '0 && i_run_min == '0 && i_run_max == '0)
        else $error("malformed error result");

    // only good frames give more than one result
    a_multi_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_last_result |-> i_status == brfc_pkg::STATUS_OK)
        else $error("non-final result with error status");

    // running extremes bracket the value
    a_bracket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == brfc_pkg::STATUS_OK |->
        i_run_min <= i_raw_value && i_raw_value <= i_run_max)
        else $error("value outside running min/max");

endmodule

bind bms_reply_frame_checker brfc_checker u_brfc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_res.valid),
    .i_ready       (o_res.ready),
    .i_status      (o_res.status),
    .i_channel     (o_res.channel),
    .i_raw_value   (o_res.raw_value),
    .i_run_min     (o_res.run_min),
    .i_run_max     (o_res.run_max),
    .i_good_count  (o_res.good_count),
    .i_bad_count   (o_res.bad_count),
    .i_last_result (o_res.last_result)
);
`default_nettype wire

// File: test/tb_bms_reply_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bms_reply_frame_checker
// Self-checking bench for the battery monitor reply frame checker.
// ----------------------------------------------------------------------------
// A short table of hand-picked bytes runs first: a one-byte frame, a good
// frame at the code extremes with a trailing ignored byte, and a two-byte
// frame. Random frames follow over several register settings: good, long,
// short, crc-broken, header-broken and noise frames. A local frame model
// tracks crc, header, stored data, running extremes and frame counters, and
// results are checked against it or a typed table row. Both sides idle in bursts.
// ----------------------------------------------------------------------------
module tb_bms_reply_frame_checker;

    localparam int FRAME_BYTES   = 22;
    localparam int CELL_COUNT    = 6;
    localparam int CHANNELS      = CELL_COUNT + 3;
    localparam int DATA_BYTES    = 2 * CHANNELS;
    localparam int PHASES        = 5;
    localparam int RANDOM_ITEMS  = 285;
    localparam int SETTLE_CYCLES = 60;
    localparam int TABLE_ROWS    = 26;

    typedef struct {
        brfc_pkg::t_status                  status;
        logic [brfc_pkg::CHAN_W-1:0]        channel;
        logic [brfc_pkg::VALUE_W-1:0]       raw_value;
        logic [brfc_pkg::VALUE_W-1:0]       run_min;
        logic [brfc_pkg::VALUE_W-1:0]       run_max;
        logic [brfc_pkg::COUNT_W-1:0]       good_count;
        logic [brfc_pkg::COUNT_W-1:0]       bad_count;
        logic                               last_result;
    } t_reading;

    typedef enum logic [1:0] {
        ROW_PLAIN,
        ROW_CRC,
        ROW_TYPED
    } t_row_kind;

    typedef struct {
        logic [brfc_pkg::BYTE_W-1:0]  data;
        logic                         eof;
        t_row_kind                    kind;
        brfc_pkg::t_status            status;
        logic [brfc_pkg::COUNT_W-1:0] good;
        logic [brfc_pkg::COUNT_W-1:0] bad;
    } t_table_row;

    typedef enum logic [2:0] {
        FRAME_GOOD,
        FRAME_LONG,
        FRAME_SHORT,
        FRAME_BAD_CRC,
        FRAME_BAD_ADDR,
        FRAME_BAD_REG,
        FRAME_BAD_LEN,
        FRAME_NOISE
    } t_frame_kind;

    logic i_clk;
    logic i_rst_n;

    brfc_rx_if  rx_ch ();
    brfc_cfg_if cfg_ch ();
    brfc_res_if res_ch ();

    bms_reply_frame_checker #(
        .FRAME_BYTES (FRAME_BYTES),
        .CELL_COUNT  (CELL_COUNT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    // frame model state
    logic [brfc_pkg::ADDR_W-1:0]  cfg_address;
    logic [brfc_pkg::BYTE_W-1:0]  cfg_register;
    int unsigned                  rx_pos;
    logic [brfc_pkg::BYTE_W-1:0]  crc_run;
    logic [brfc_pkg::BYTE_W-1:0]  crc_seen;
    logic                         hdr_good;
    logic [brfc_pkg::BYTE_W-1:0]  stored [DATA_BYTES];
    logic [brfc_pkg::VALUE_W-1:0] lo_module;
    logic [brfc_pkg::VALUE_W-1:0] hi_module;
    logic [brfc_pkg::VALUE_W-1:0] lo_cell [CELL_COUNT];
    logic [brfc_pkg::VALUE_W-1:0] hi_cell [CELL_COUNT];
    logic [brfc_pkg::COUNT_W-1:0] ok_frames;
    logic [brfc_pkg::COUNT_W-1:0] failed_frames;
    t_reading                     fresh [CHANNELS];
    int                           fresh_count;

    t_reading pending_readings [$];
    int       mismatches;
    int       readings_seen;
    int       bytes_used;
    int       frames_sent;
    int       idle_odds;

    t_table_row reply_table [TABLE_ROWS] = '{
        '{8'hFF, 1'b1, ROW_TYPED, brfc_pkg::STATUS_SHORT, 32'd0, 32'd1},
        '{8'h00, 1'b0, ROW_PLAIN, brfc_pkg::STATUS_OK, 32'd0, 32'd0},
        '{8'h01, 1'b0, ROW_PLAIN, brfc_pkg::STATUS_OK, 32'd0, 32'd0},
        '{8'h12, 1'b0, ROW_PLAIN, brfc_pkg::STATUS_OK, 32'd0, 32'd0},
        '{8'hFF, 1'b0, ROW_PLAIN, brfc_pkg::STATUS_OK, 32'd0, 32'd0},
        '{8'hFF, 1'b0, ROW_PLAIN, brfc_pkg::STATUS_OK, 32'd0, 32'd0},
        '{8'h00, 1'b0, ROW_PLAIN, brfc_pkg::STATUS_OK, 32'd0, 32'd0},
        '{8'h00, 1'b0, ROW_PLAIN, brfc_pkg::STATUS_OK, 32'd0, 32'd0},
        '{8'hFF, 1'b0, ROW_PLAIN, brfc_pkg::STATUS_OK, 32'd0, 32'd0},
        '{8'hFF, 1'b0, ROW_PLAIN, brfc_pkg::STATUS_OK, 32'd0, 32'd0},
        '{8'h33, 1'b0, ROW_PLAIN, brfc_pkg::STATUS_OK, 32'd0, 32'd0},
        '{8'h33, 1'b0, ROW_PLAIN, brfc_pkg::STATUS_OK, 32'd0, 32'd0},
        '{8'h33, 1'b0, ROW_PLAIN, brfc_pkg::STATUS_OK, 32'd0, 32'd0},
        '{8'h32, 1'b0, ROW_PLAIN, brfc_pkg::STATUS_OK, 32'd0, 32'd0},
        '{8'h80, 1'b0, ROW_PLAIN, brfc_pkg::STATUS_OK, 32'd0, 32'd0},
        '{8'h01, 1'b0, ROW_PLAIN, brfc_pkg::STATUS_OK, 32'd0, 32'd0},
        '{8'h7F, 1'b0, ROW_PLAIN, brfc_pkg::STATUS_OK, 32'd0, 32'd0},
        '{8'hFE, 1'b0, ROW_PLAIN, brfc_pkg::STATUS_OK, 32'd0, 32'd0},
        '{8'h00, 1'b0, ROW_PLAIN, brfc_pkg::STATUS_OK, 32'd0, 32'd0},
        '{8'h00, 1'b0, ROW_PLAIN, brfc_pkg::STATUS_OK, 32'd0, 32'd0},
        '{8'hFF, 1'b0, ROW_PLAIN, brfc_pkg::STATUS_OK, 32'd0, 32'd0},
        '{8'hFF, 1'b0, ROW_PLAIN, brfc_pkg::STATUS_OK, 32'd0, 32'd0},
        '{8'h00, 1'b0, ROW_CRC,   brfc_pkg::STATUS_OK, 32'd0, 32'd0},
        // byte past the frame length, ignored but carries the frame end
        '{8'hA5, 1'b1, ROW_PLAIN, brfc_pkg::STATUS_OK, 32'd0, 32'd0},
        '{8'h00, 1'b0, ROW_PLAIN, brfc_pkg::STATUS_OK, 32'd0, 32'd0},
        '{8'h5A, 1'b1, ROW_TYPED, brfc_pkg::STATUS_SHORT, 32'd1, 32'd2}
    };

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // bitwise msb-first crc-8 step, polynomial 0x07
    function automatic logic [brfc_pkg::BYTE_W-1:0] crc8_step(
        input logic [brfc_pkg::BYTE_W-1:0] crc,
        input logic [brfc_pkg::BYTE_W-1:0] b);
        logic [brfc_pkg::BYTE_W-1:0] c;
        logic                        fb;
        c = crc;
        for (int i = brfc_pkg::BYTE_W - 1; i >= 0; i--) begin
            fb = c[7] ^ b[i];
            c  = {c[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
        end
        return c;
    endfunction

    function automatic t_reading error_reading(input brfc_pkg::t_status s,
                                               input logic [brfc_pkg::COUNT_W-1:0] good,
                                               input logic [brfc_pkg::COUNT_W-1:0] bad);
        t_reading r;
        r = '{s, '0, '0, '0, '0, good, bad, 1'b1};
        return r;
    endfunction

    // advances the frame model by one accepted byte; fills fresh[] at frame end
    function automatic void absorb_reply_byte(input logic [brfc_pkg::BYTE_W-1:0] b,
                                              input logic eof);
        logic [brfc_pkg::VALUE_W-1:0] code [CHANNELS];
        logic [brfc_pkg::VALUE_W-1:0] lo;
        logic [brfc_pkg::VALUE_W-1:0] hi;
        fresh_count = 0;
        if (rx_pos < FRAME_BYTES) begin
            if (rx_pos < FRAME_BYTES - 1) crc_run = crc8_step(crc_run, b);
            else crc_seen = b;
            if (rx_pos == 0 && b != {1'b0, cfg_address, 1'b0}) hdr_good = 1'b0;
            if (rx_pos == 1 && b != cfg_register) hdr_good = 1'b0;
            if (rx_pos == 2 && b != 8'(DATA_BYTES)) hdr_good = 1'b0;
            if (rx_pos >= 3 && rx_pos - 3 < DATA_BYTES && rx_pos < FRAME_BYTES - 1)
                stored[rx_pos - 3] = b;
            rx_pos++;
        end
        if (!eof) return;

        if (rx_pos < FRAME_BYTES) begin
            failed_frames++;
            fresh[0] = error_reading(brfc_pkg::STATUS_SHORT, ok_frames, failed_frames);
            fresh_count = 1;
        end else if (crc_seen != crc_run) begin
            failed_frames++;
            fresh[0] = error_reading(brfc_pkg::STATUS_CRC, ok_frames, failed_frames);
            fresh_count = 1;
        end else if (!hdr_good) begin
            fresh[0] = error_reading(brfc_pkg::STATUS_HEADER, ok_frames, failed_frames);
            fresh_count = 1;
        end else begin
            for (int c = 0; c < CHANNELS; c++) code[c] = {stored[2*c], stored[2*c+1]};
            if (code[0] > hi_module) hi_module = code[0];
            if (code[0] < lo_module) lo_module = code[0];
            for (int c = 0; c < CELL_COUNT; c++) begin
                if (code[c+1] < lo_cell[c]) lo_cell[c] = code[c+1];
                if (code[c+1] > hi_cell[c]) hi_cell[c] = code[c+1];
            end
            ok_frames++;
            for (int c = 0; c < CHANNELS; c++) begin
                if (c == 0) begin
                    lo = lo_module;
                    hi = hi_module;
                end else if (c <= CELL_COUNT) begin
                    lo = lo_cell[c-1];
                    hi = hi_cell[c-1];
                end else begin
                    lo = code[c];
                    hi = code[c];
                end
                fresh[c] = '{brfc_pkg::STATUS_OK, brfc_pkg::CHAN_W'(c), code[c], lo, hi,
                             ok_frames, failed_frames, (c == CHANNELS - 1)};
            end
            fresh_count = CHANNELS;
        end
        rx_pos   = 0;
        crc_run  = '0;
        hdr_good = 1'b1;
    endfunction

    task automatic send_byte(input logic [brfc_pkg::BYTE_W-1:0] b, input logic eof,
                             input bit typed);
        if (idle_odds != 0 && $urandom_range(0, 7) < idle_odds) begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        rx_ch.valid        <= 1'b1;
        rx_ch.rx_byte      <= b;
        rx_ch.end_of_frame <= eof;
        do @(posedge i_clk); while (!rx_ch.ready);
        if (rx_pos < FRAME_BYTES) bytes_used++;
        if (eof) frames_sent++;
        absorb_reply_byte(b, eof);
        if (!typed)
            for (int k = 0; k < fresh_count; k++) pending_readings.push_back(fresh[k]);
    endtask

    task automatic wait_drained();
        rx_ch.valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input brfc_pkg::t_reg_index idx,
                                  input logic [brfc_pkg::BYTE_W-1:0] value);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wr_data   <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            brfc_pkg::REG_MODULE_ADDRESS: cfg_address  = value[brfc_pkg::ADDR_W-1:0];
            brfc_pkg::REG_DATA_REGISTER:  cfg_register = value;
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [brfc_pkg::COUNT_W-1:0] want,
                               input logic [brfc_pkg::COUNT_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // result side: random stall bursts
    initial begin
        int stall_left;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left == 0 && idle_odds != 0 && $urandom_range(0, 7) < idle_odds)
                stall_left = $urandom_range(1, 6);
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // result checker
    initial begin
        t_reading want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                if (pending_readings.size() == 0) begin
                    $error("unexpected result transfer: status %0d channel %0d",
                           res_ch.status, res_ch.channel);
                    mismatches++;
                end else begin
                    want = pending_readings.pop_front();
                    check_field("status", want.status, res_ch.status);
                    check_field("channel", want.channel, res_ch.channel);
                    check_field("raw_value", want.raw_value, res_ch.raw_value);
                    check_field("run_min", want.run_min, res_ch.run_min);
                    check_field("run_max", want.run_max, res_ch.run_max);
                    check_field("good_count", want.good_count, res_ch.good_count);
                    check_field("bad_count", want.bad_count, res_ch.bad_count);
                    check_field("last_result", want.last_result, res_ch.last_result);
                    readings_seen++;
                end
            end
        end
    end

    initial begin
        #(2_000_000);
        $error("timeout with %0d results outstanding", pending_readings.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        logic [brfc_pkg::BYTE_W-1:0] frame [$];
        logic [brfc_pkg::BYTE_W-1:0] b;
        logic [brfc_pkg::BYTE_W-1:0] crc;
        logic [brfc_pkg::ADDR_W-1:0] new_addr;
        logic [brfc_pkg::BYTE_W-1:0] new_reg;
        t_frame_kind                 kind;
        int                          frames_built;
        int                          base_used;
        int                          r;

        i_rst_n             <= 1'b0;
        rx_ch.valid         <= 1'b0;
        rx_ch.rx_byte       <= '0;
        rx_ch.end_of_frame  <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.reg_index    <= '0;
        cfg_ch.wr_data      <= '0;

        cfg_address   = '0;
        cfg_register  = brfc_pkg::DATA_REG_RESET;
        rx_pos        = 0;
        crc_run       = '0;
        crc_seen      = '0;
        hdr_good      = 1'b1;
        lo_module     = brfc_pkg::MIN_MODULE_RESET;
        hi_module     = brfc_pkg::MAX_RESET;
        ok_frames     = '0;
        failed_frames = '0;
        foreach (stored[i]) stored[i] = '0;
        foreach (lo_cell[i]) begin
            lo_cell[i] = brfc_pkg::MIN_CELL_RESET;
            hi_cell[i] = brfc_pkg::MAX_RESET;
        end
        mismatches    = 0;
        readings_seen = 0;
        bytes_used    = 0;
        frames_sent   = 0;
        frames_built  = 0;
        idle_odds     = 2;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, register values as after reset
        foreach (reply_table[i]) begin
            b = (reply_table[i].kind == ROW_CRC) ? crc_run : reply_table[i].data;
            send_byte(b, reply_table[i].eof, reply_table[i].kind == ROW_TYPED);
            if (reply_table[i].kind == ROW_TYPED)
                pending_readings.push_back(error_reading(reply_table[i].status,
                                                         reply_table[i].good,
                                                         reply_table[i].bad));
        end

        base_used = bytes_used;
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            case (phase)
                0: begin
                    new_addr = 6'd63;
                    new_reg  = 8'hFF;
                end
                1: begin
                    new_addr = 6'd0;
                    new_reg  = 8'h00;
                end
                default: begin
                    new_addr = 6'($urandom_range(0, 63));
                    new_reg  = 8'($urandom_range(0, 255));
                end
            endcase
            write_register(brfc_pkg::REG_MODULE_ADDRESS, {2'b00, new_addr});
            write_register(brfc_pkg::REG_DATA_REGISTER, new_reg);

            while (bytes_used < base_used + RANDOM_ITEMS * (phase + 1) / PHASES) begin
                idle_odds = (phase == PHASES - 1) ? 0 : $urandom_range(0, 3);
                // walk every frame kind once before weighting toward good frames
                if (frames_built < 8) begin
                    kind = t_frame_kind'(frames_built);
                end else begin
                    r = $urandom_range(0, 19);
                    kind = (r < 10) ? FRAME_GOOD : (r < 12) ? FRAME_LONG :
                           (r < 14) ? FRAME_SHORT : (r < 16) ? FRAME_BAD_CRC :
                           (r == 16) ? FRAME_BAD_ADDR : (r == 17) ? FRAME_BAD_REG :
                           (r == 18) ? FRAME_BAD_LEN : FRAME_NOISE;
                end
                frames_built++;

                frame.delete();
                frame.push_back({1'b0, cfg_address, 1'b0});
                frame.push_back(cfg_register);
                frame.push_back(8'(DATA_BYTES));
                while (frame.size() < FRAME_BYTES - 1) begin
                    r = $urandom_range(0, 9);
                    frame.push_back((r == 0) ? 8'h00 : (r == 1) ? 8'hFF :
                                    8'($urandom_range(0, 255)));
                end
                case (kind)
                    FRAME_BAD_ADDR: frame[0] ^= 8'($urandom_range(1, 255));
                    FRAME_BAD_REG:  frame[1] ^= 8'($urandom_range(1, 255));
                    FRAME_BAD_LEN:  frame[2] ^= 8'($urandom_range(1, 255));
                    default: ;
                endcase
                crc = '0;
                foreach (frame[j]) crc = crc8_step(crc, frame[j]);
                if (kind == FRAME_BAD_CRC) crc ^= 8'($urandom_range(1, 255));
                frame.push_back(crc);
                case (kind)
                    FRAME_SHORT: begin
                        r = $urandom_range(1, FRAME_BYTES - 1);
                        while (frame.size() > r) void'(frame.pop_back());
                    end
                    FRAME_LONG:
                        repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom_range(0, 255)));
                    FRAME_NOISE: begin
                        frame.delete();
                        repeat ($urandom_range(1, 30)) frame.push_back(8'($urandom_range(0, 255)));
                    end
                    default: ;
                endcase

                foreach (frame[j]) send_byte(frame[j], j == frame.size() - 1, 1'b0);
                if ($urandom_range(0, 9) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("run covered %0d counted reply bytes in %0d frames over %0d register settings",
                 bytes_used, frames_sent, PHASES + 1);
        $display("checked %0d result transfers, %0d frames good, %0d counted bad",
                 readings_seen, ok_frames, failed_frames);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
